/* src/arpc_pkg.sv */
`default_nettype none
package arpc_pkg;
  localparam int CacheDepthDef   = 128;
  localparam int PendingDepthDef = 16;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUEUE  = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [3:0] K_HIT     = 4'd0;
  localparam logic [3:0] K_MISS    = 4'd1;
  localparam logic [3:0] K_INS     = 4'd2;
  localparam logic [3:0] K_DROP    = 4'd3;
  localparam logic [3:0] K_QUEUED  = 4'd4;
  localparam logic [3:0] K_EXISTS  = 4'd5;
  localparam logic [3:0] K_FULL    = 4'd6;
  localparam logic [3:0] K_SEND    = 4'd7;
  localparam logic [3:0] K_GIVEUP  = 4'd8;
  localparam logic [3:0] K_TICKEND = 4'd9;

  localparam logic [1:0] CFG_MAX_TRIES = 2'd0;
  localparam logic [1:0] CFG_RETRY     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        had;
    logic [3:0]  tries;
    logic        last;
  } res_t;
endpackage
`default_nettype wire

/* src/arpc_out_reg.sv */
`default_nettype none
module arpc_out_reg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire arpc_pkg::res_t push_data,
  output logic              full,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output arpc_pkg::res_t    out_data
);
  import arpc_pkg::*;
  logic valid_r;
  res_t data_r;

  // single result holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign full       = valid_r && !out_tready;
  assign out_tvalid = valid_r;
  assign out_data   = data_r;
endmodule
`default_nettype wire

/* src/arp_cache_with_request_retry_top.sv */
// channel | dir | tdata (low bit up)            | tuser | tlast
// in      | in  | operation[1:0] ip mac, 88 bits | -     | -
// out     | out | kind ip mac had_pending tries  | -     | last
// cfg     | in  | index 2 bits, data 16 bits     | -     | -
// from accept to the next accept: a lookup walks the cache table, a queue the request table;
// an insert or a tick walks both tables;
// one memory read per cycle while the request sweep is not held.
// reset clears valid marks in flip-flops; memories need no clearing pass.
// a stalled result holds the request sweep while a due request waits; one item is worked at a time.
`default_nettype none
module arp_cache_with_request_retry_top #(
  parameter int CACHE_DEPTH   = arpc_pkg::CacheDepthDef,
  parameter int PENDING_DEPTH = arpc_pkg::PendingDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // operation[1:0], ip[33:2], mac[81:34]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // kind[3:0], ip[35:4], mac[83:36], had[84], tries[88:85]
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import arpc_pkg::*;
  localparam int CW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CSCAN = 3'd1;
  localparam logic [2:0] S_PSCAN = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_TEND  = 3'd4;

  // configuration registers
  logic [3:0]  max_tries_r;
  logic [7:0]  retry_r;
  logic [15:0] timeout_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tries_r <= 4'd5;
      retry_r     <= 8'd1;
      timeout_r   <= 16'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_TRIES: max_tries_r <= cfg_data[3:0];
        CFG_RETRY:     retry_r     <= cfg_data[7:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories and valid marks
  logic [31:0] c_ip_m  [CACHE_DEPTH];
  logic [47:0] c_mac_m [CACHE_DEPTH];
  logic [15:0] c_age_m [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] c_val_r;
  logic [31:0] p_ip_m  [PENDING_DEPTH];
  logic [3:0]  p_tr_m  [PENDING_DEPTH];
  logic [7:0]  p_wt_m  [PENDING_DEPTH];
  logic [PENDING_DEPTH-1:0] p_val_r;

  logic [2:0]  state_r;
  logic [1:0]  op_r;
  logic [31:0] ip_r;
  logic [47:0] mac_r;
  logic [CW:0] ca_r;         // read address issued
  logic [PW:0] pa_r;
  logic        rd_ok_r;      // read data in flight is valid
  logic [CW-1:0] rd_cidx_r;
  logic [PW-1:0] rd_pidx_r;
  logic [31:0] c_ip_q, p_ip_q;
  logic [47:0] c_mac_q;
  logic [15:0] c_age_q;
  logic [3:0]  p_tr_q;
  logic [7:0]  p_wt_q;
  // scan results
  logic        hit_r;
  logic [47:0] hmac_r;
  logic        free_found_r;
  logic [CW-1:0] free_idx_r;
  logic        pfound_r;
  logic [PW-1:0] pidx_r;
  logic [3:0]  ptr_r;
  logic        pfree_found_r;
  logic [PW-1:0] pfree_r;

  logic push, ofull;
  res_t push_d, odata;

  arpc_out_reg u_out (
    .clk, .rst_n, .push, .push_data(push_d), .full(ofull),
    .out_tvalid, .out_tready, .out_data(odata)
  );
  assign out_tdata = {7'd0, odata.tries, odata.had, odata.mac, odata.ip, odata.kind};
  assign out_tlast = odata.last;
  assign in_tready = (state_r == S_IDLE);

  logic c_match, p_match, pdue, pgive;
  logic [15:0] age_inc;
  logic [3:0]  tr_inc;
  assign c_match = c_val_r[rd_cidx_r] && (c_ip_q == ip_r);
  assign p_match = p_val_r[rd_pidx_r] && (p_ip_q == ip_r);
  assign age_inc = (c_age_q == 16'hFFFF) ? c_age_q : c_age_q + 16'd1;
  assign pdue    = p_wt_q <= 8'd1;
  assign pgive   = p_tr_q >= max_tries_r;
  assign tr_inc  = (p_tr_q == 4'hF) ? p_tr_q : p_tr_q + 4'd1;

  // sweep stall while a due request waits for the result register
  logic pstall;
  assign pstall = state_r == S_PSCAN && op_r == OP_TICK && rd_ok_r && p_val_r[rd_pidx_r]
                  && pdue && ofull;

  // synchronous reads; request data is held while the sweep stalls
  always_ff @(posedge clk) begin
    c_ip_q  <= c_ip_m[ca_r[CW-1:0]];
    c_mac_q <= c_mac_m[ca_r[CW-1:0]];
    c_age_q <= c_age_m[ca_r[CW-1:0]];
    if (!pstall) begin
      p_ip_q <= p_ip_m[pa_r[PW-1:0]];
      p_tr_q <= p_tr_m[pa_r[PW-1:0]];
      p_wt_q <= p_wt_m[pa_r[PW-1:0]];
    end
  end

  always_comb begin
    push   = 1'b0;
    push_d = '0;
    if (state_r == S_EMIT && !ofull) begin
      push          = 1'b1;
      push_d.ip     = ip_r;
      push_d.last   = 1'b1;
      unique case (op_r)
        OP_LOOKUP: begin
          push_d.kind = hit_r ? K_HIT : K_MISS;
          push_d.mac  = hit_r ? hmac_r : 48'd0;
        end
        OP_INSERT: begin
          push_d.kind  = free_found_r ? K_INS : K_DROP;
          push_d.had   = pfound_r;
          push_d.tries = pfound_r ? ptr_r : 4'd0;
        end
        default: begin
          push_d.kind  = pfound_r ? K_EXISTS : (pfree_found_r ? K_QUEUED : K_FULL);
          push_d.tries = pfound_r ? ptr_r : 4'd0;
        end
      endcase
    end else if (state_r == S_PSCAN && op_r == OP_TICK && rd_ok_r && !ofull
                 && p_val_r[rd_pidx_r] && pdue) begin
      push        = 1'b1;
      push_d.kind = pgive ? K_GIVEUP : K_SEND;
      push_d.ip   = p_ip_q;
      push_d.tries = pgive ? p_tr_q : tr_inc;
    end else if (state_r == S_TEND && !ofull) begin
      push        = 1'b1;
      push_d.kind = K_TICKEND;
      push_d.last = 1'b1;
    end
  end

  // sweep sequencer; read address advances one slot per cycle unless the request sweep stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      c_val_r <= '0;
      p_val_r <= '0;
      rd_ok_r <= 1'b0;
      ca_r    <= '0;
      pa_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          rd_ok_r <= 1'b0;
          ca_r    <= '0;
          pa_r    <= '0;
          if (in_tvalid) begin
            op_r  <= in_tdata[1:0];
            ip_r  <= in_tdata[33:2];
            mac_r <= in_tdata[81:34];
            hit_r <= 1'b0;
            free_found_r  <= 1'b0;
            pfound_r      <= 1'b0;
            pfree_found_r <= 1'b0;
            state_r <= (in_tdata[1:0] == OP_QUEUE) ? S_PSCAN : S_CSCAN;
          end
        end
        S_CSCAN: begin
          // result of previous read
          if (rd_ok_r) begin
            if (op_r == OP_TICK) begin
              if (c_val_r[rd_cidx_r]) begin
                c_age_m[rd_cidx_r] <= age_inc;
                if (age_inc > timeout_r) c_val_r[rd_cidx_r] <= 1'b0;
              end
            end else if (c_match) begin
              hit_r  <= 1'b1;
              hmac_r <= c_mac_q;
            end
          end
          if (ca_r == (CW+1)'(CACHE_DEPTH)) begin
            rd_ok_r <= 1'b0;
            state_r <= (op_r == OP_LOOKUP) ? S_EMIT : S_PSCAN;
          end else begin
            rd_cidx_r <= ca_r[CW-1:0];
            rd_ok_r   <= 1'b1;
            if (op_r == OP_INSERT && !free_found_r && !c_val_r[ca_r[CW-1:0]]) begin
              free_found_r <= 1'b1;
              free_idx_r   <= ca_r[CW-1:0];
            end
            ca_r <= ca_r + 1'b1;
          end
        end
        S_PSCAN: begin
          if (!pstall) begin
            if (rd_ok_r && p_val_r[rd_pidx_r]) begin
              if (op_r == OP_TICK) begin
                if (!pdue) begin
                  p_wt_m[rd_pidx_r] <= p_wt_q - 8'd1;
                end else if (pgive) begin
                  p_val_r[rd_pidx_r] <= 1'b0;
                end else begin
                  p_tr_m[rd_pidx_r] <= tr_inc;
                  p_wt_m[rd_pidx_r] <= retry_r;
                end
              end else if (p_match && !pfound_r) begin
                pfound_r <= 1'b1;
                pidx_r   <= rd_pidx_r;
                ptr_r    <= p_tr_q;
              end
            end
            if (pa_r == (PW+1)'(PENDING_DEPTH)) begin
              rd_ok_r <= 1'b0;
              state_r <= (op_r == OP_TICK) ? S_TEND : S_EMIT;
            end else begin
              rd_pidx_r <= pa_r[PW-1:0];
              rd_ok_r   <= 1'b1;
              if (!pfree_found_r && !p_val_r[pa_r[PW-1:0]]) begin
                pfree_found_r <= 1'b1;
                pfree_r       <= pa_r[PW-1:0];
              end
              pa_r <= pa_r + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (!ofull) begin
            state_r <= S_IDLE;
            if (op_r == OP_INSERT) begin
              if (pfound_r) p_val_r[pidx_r] <= 1'b0;
              if (free_found_r) begin
                c_val_r[free_idx_r] <= 1'b1;
                c_ip_m[free_idx_r]  <= ip_r;
                c_mac_m[free_idx_r] <= mac_r;
                c_age_m[free_idx_r] <= 16'd0;
              end
            end else if (op_r == OP_QUEUE && !pfound_r && pfree_found_r) begin
              p_val_r[pfree_r] <= 1'b1;
              p_ip_m[pfree_r]  <= ip_r;
              p_tr_m[pfree_r]  <= 4'd0;
              p_wt_m[pfree_r]  <= 8'd0;
            end
          end
        end
        S_TEND: begin
          if (!ofull) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* tb/sv/arp_cache_with_request_retry_top_test.sv */
`timescale 1ns / 100ps
`default_nettype none
module arp_cache_with_request_retry_top_test;
  import arpc_pkg::*;

  localparam int NCACHE  = CacheDepthDef;
  localparam int NPEND   = PendingDepthDef;
  localparam int DRAIN   = 220;
  localparam int WD_MAX  = 6000;
  localparam int HOLD_CY = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MAX_TRIES;
  logic [15:0] cfg_data = '0;

  arp_cache_with_request_retry_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow copy of the cache and request tables
  logic [3:0]  sh_max_tries;
  logic [7:0]  sh_retry;
  logic [15:0] sh_timeout;
  logic        ent_vld [NCACHE];
  logic [31:0] ent_ip  [NCACHE];
  logic [47:0] ent_mac [NCACHE];
  logic [15:0] ent_age [NCACHE];
  logic        req_vld [NPEND];
  logic [31:0] req_ip  [NPEND];
  logic [3:0]  req_tries [NPEND];
  logic [7:0]  req_wait  [NPEND];

  res_t arp_answers[$];
  int   n_items = 0, n_beats = 0, n_ticks = 0, n_bad = 0;
  bit   quiet = 1'b0;
  int   hold_seq = 0;

  function automatic res_t mk(logic [3:0] k, logic [31:0] ip, logic [47:0] mac,
                              logic had, logic [3:0] tries, logic last);
    res_t r;
    r.kind = k; r.ip = ip; r.mac = mac; r.had = had; r.tries = tries; r.last = last;
    return r;
  endfunction

  // work out the answers of one accepted beat and update the shadow tables
  function automatic void arp_predict(logic [1:0] op, logic [31:0] ip, logic [47:0] mac);
    int hit, p, f;
    logic had;
    logic [3:0] tr;
    hit = -1; p = -1; f = -1; had = 1'b0; tr = '0;
    case (op)
      OP_LOOKUP: begin
        for (int i = 0; i < NCACHE; i++)
          if (ent_vld[i] && ent_ip[i] == ip) hit = i;
        if (hit >= 0) arp_answers.push_back(mk(K_HIT, ip, ent_mac[hit], 1'b0, '0, 1'b1));
        else arp_answers.push_back(mk(K_MISS, ip, '0, 1'b0, '0, 1'b1));
      end
      OP_INSERT: begin
        for (int i = NPEND - 1; i >= 0; i--)
          if (req_vld[i] && req_ip[i] == ip) p = i;
        if (p >= 0) begin
          had = 1'b1; tr = req_tries[p]; req_vld[p] = 1'b0;
        end
        for (int i = NCACHE - 1; i >= 0; i--)
          if (!ent_vld[i]) f = i;
        if (f >= 0) begin
          ent_vld[f] = 1'b1; ent_ip[f] = ip; ent_mac[f] = mac; ent_age[f] = '0;
          arp_answers.push_back(mk(K_INS, ip, '0, had, tr, 1'b1));
        end else begin
          arp_answers.push_back(mk(K_DROP, ip, '0, had, tr, 1'b1));
        end
      end
      OP_QUEUE: begin
        for (int i = NPEND - 1; i >= 0; i--)
          if (req_vld[i] && req_ip[i] == ip) p = i;
        for (int i = NPEND - 1; i >= 0; i--)
          if (!req_vld[i]) f = i;
        if (p >= 0) begin
          arp_answers.push_back(mk(K_EXISTS, ip, '0, 1'b0, req_tries[p], 1'b1));
        end else if (f >= 0) begin
          req_vld[f] = 1'b1; req_ip[f] = ip; req_tries[f] = '0; req_wait[f] = '0;
          arp_answers.push_back(mk(K_QUEUED, ip, '0, 1'b0, '0, 1'b1));
        end else begin
          arp_answers.push_back(mk(K_FULL, ip, '0, 1'b0, '0, 1'b1));
        end
      end
      default: begin
        for (int i = 0; i < NCACHE; i++) begin
          if (ent_vld[i]) begin
            if (ent_age[i] != 16'hFFFF) ent_age[i]++;
            if (ent_age[i] > sh_timeout) ent_vld[i] = 1'b0;
          end
        end
        for (int i = 0; i < NPEND; i++) begin
          if (req_vld[i]) begin
            if (req_wait[i] > 1) begin
              req_wait[i]--;
            end else if (req_tries[i] >= sh_max_tries) begin
              arp_answers.push_back(mk(K_GIVEUP, req_ip[i], '0, 1'b0, req_tries[i], 1'b0));
              req_vld[i] = 1'b0;
            end else begin
              if (req_tries[i] != 4'hF) req_tries[i]++;
              req_wait[i] = sh_retry;
              arp_answers.push_back(mk(K_SEND, req_ip[i], '0, 1'b0, req_tries[i], 1'b0));
            end
          end
        end
        arp_answers.push_back(mk(K_TICKEND, '0, '0, 1'b0, '0, 1'b1));
      end
    endcase
  endfunction

  // result side: random stall bursts, long hold-off on request
  int stall_left = 0, hold_left = 0, hold_seen = 0;
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CY;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && rst_n && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(1, 15) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t got, want;
    if (out_tvalid && out_tready) begin
      n_beats++;
      got = mk(out_tdata[3:0], out_tdata[35:4], out_tdata[83:36], out_tdata[84],
               out_tdata[88:85], out_tlast);
      if (arp_answers.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = arp_answers.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("mismatch: expected kind %0d ip %h mac %h had %b tries %0d last %b",
                     want.kind, want.ip, want.mac, want.had, want.tries, want.last);
            $display("          got kind %0d ip %h mac %h had %b tries %0d last %b",
                     got.kind, got.ip, got.mac, got.had, got.tries, got.last);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  int idle_cy = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cy <= 0;
    else idle_cy <= idle_cy + 1;
    if (idle_cy >= WD_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one beat into the block; valid stays high for a back-to-back beat
  task automatic send_beat(logic [1:0] op, logic [31:0] ip, logic [47:0] mac,
                           bit typed = 1'b0, res_t fixed = '0);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, mac, ip, op};
    do @(posedge clk); while (!in_tready);
    n_items++;
    if (op == OP_TICK) n_ticks++;
    if (typed) begin
      arp_predict(op, ip, mac);
      void'(arp_answers.pop_back());
      arp_answers.push_back(fixed);
    end else begin
      arp_predict(op, ip, mac);
    end
  endtask

  // sender pause until every answer has come and the block has settled
  task automatic settle();
    in_tvalid <= 1'b0;
    while (arp_answers.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_cfg(logic [3:0] mt, logic [7:0] rt, logic [15:0] to);
    settle();
    cfg_we <= 1'b1; cfg_index <= CFG_MAX_TRIES; cfg_data <= {12'd0, mt};
    @(posedge clk);
    cfg_index <= CFG_RETRY; cfg_data <= {8'd0, rt};
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT; cfg_data <= to;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_max_tries = mt; sh_retry = rt; sh_timeout = to;
  endtask

  typedef struct {
    logic [1:0]  op;
    logic [31:0] ip;
    logic [47:0] mac;
    bit          typed;
    logic [3:0]  kind;
    logic [47:0] rmac;
  } row_t;

  localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;

  row_t dir_rows [0:22] = '{
    '{OP_LOOKUP, 32'h0,         48'h0,           1, K_MISS, 48'h0},
    '{OP_LOOKUP, 32'hFFFF_FFFF, MAC_ONES,        1, K_MISS, 48'h0},
    '{OP_INSERT, 32'hFFFF_FFFF, MAC_ONES,        1, K_INS,  48'h0},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 48'h0,           1, K_HIT,  MAC_ONES},
    '{OP_INSERT, 32'h0,         48'h0,           1, K_INS,  48'h0},
    '{OP_INSERT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 0, K_HIT, 48'h0},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 48'h0,           0, K_HIT,  48'h0},
    '{OP_QUEUE,  32'h0A00_0001, 48'h0,           0, K_HIT,  48'h0},
    '{OP_QUEUE,  32'h0A00_0001, MAC_ONES,        0, K_HIT,  48'h0},
    '{OP_QUEUE,  32'h0,         48'hA5A5_5A5A_A5A5, 0, K_HIT, 48'h0},
    '{OP_TICK,   32'hDEAD_BEEF, MAC_ONES,        0, K_HIT,  48'h0},
    '{OP_TICK,   32'h0,         48'h0,           0, K_HIT,  48'h0},
    '{OP_QUEUE,  32'h0A00_0002, 48'h0,           0, K_HIT,  48'h0},
    '{OP_INSERT, 32'h0A00_0001, 48'h0000_0000_0001, 0, K_HIT, 48'h0},
    '{OP_LOOKUP, 32'h0A00_0001, 48'h0,           0, K_HIT,  48'h0},
    '{OP_TICK,   32'h0,         48'h0,           0, K_HIT,  48'h0},
    '{OP_TICK,   32'h0,         48'h0,           0, K_HIT,  48'h0},
    '{OP_TICK,   32'h0,         48'h0,           0, K_HIT,  48'h0},
    '{OP_TICK,   32'h0,         48'h0,           0, K_HIT,  48'h0},
    '{OP_TICK,   32'h0,         48'h0,           0, K_HIT,  48'h0},
    '{OP_TICK,   32'h0,         48'h0,           0, K_HIT,  48'h0},
    '{OP_QUEUE,  32'h0A00_0002, 48'h0,           0, K_HIT,  48'h0},
    '{OP_LOOKUP, 32'h0,         48'h0,           0, K_HIT,  48'h0}
  };

  logic [31:0] ip_pool [12];

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 7) == 0) return $urandom();
    return ip_pool[$urandom_range(0, 11)];
  endfunction

  initial begin
    int r;
    logic [1:0] op;
    sh_max_tries = 4'd5; sh_retry = 8'd1; sh_timeout = 16'd15;
    for (int i = 0; i < NCACHE; i++) begin
      ent_vld[i] = 0; ent_ip[i] = '0; ent_mac[i] = '0; ent_age[i] = '0;
    end
    for (int i = 0; i < NPEND; i++) begin
      req_vld[i] = 0; req_ip[i] = '0; req_tries[i] = '0; req_wait[i] = '0;
    end
    for (int i = 0; i < 12; i++) ip_pool[i] = $urandom();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under reset settings
    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].ip, dir_rows[i].mac, dir_rows[i].typed,
                mk(dir_rows[i].kind, dir_rows[i].ip, dir_rows[i].rmac, 1'b0, '0, 1'b1));

    // zero settings: immediate give-up, expiry on first tick
    set_cfg(4'd0, 8'd0, 16'd0);
    send_beat(OP_QUEUE, 32'hC0A8_0001, '0);
    send_beat(OP_INSERT, 32'hC0A8_0002, 48'h0102_0304_0506);
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_LOOKUP, 32'hC0A8_0002, '0);
    set_cfg(4'd3, 8'd0, 16'd1);
    send_beat(OP_QUEUE, 32'hC0A8_0003, '0);
    repeat (5) send_beat(OP_TICK, '0, '0);

    // top extremes: fill the request table and the cache past full
    set_cfg(4'd15, 8'd255, 16'hFFFF);
    for (int i = 0; i < NPEND + 1; i++) send_beat(OP_QUEUE, 32'h0B00_0000 + i, '0);
    send_beat(OP_QUEUE, 32'h0B00_0003, '0);
    send_beat(OP_TICK, '0, '0);
    for (int i = 0; i < NCACHE + 2; i++)
      send_beat(OP_INSERT, (i < 4) ? 32'h0B00_0000 + i : $urandom(),
                48'({$urandom(), $urandom()}));
    send_beat(OP_LOOKUP, 32'h0B00_0002, '0);
    repeat (2) send_beat(OP_TICK, '0, '0);

    // random traffic over several mid settings; long result hold-off first
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_cfg(4'd15, 8'd1, 16'd3);
        1: set_cfg(4'($urandom_range(1, 4)), 8'($urandom_range(1, 3)),
                   16'($urandom_range(2, 8)));
        default: set_cfg(4'd1, 8'd2, 16'd5);
      endcase
      if (ph == 0) hold_seq = hold_seq + 1;
      for (int k = 0; k < 42; k++) begin
        if (ph == 2 && k >= 10) quiet = 1'b1;
        r = $urandom_range(0, 99);
        op = (r < 30) ? OP_LOOKUP : (r < 55) ? OP_INSERT : (r < 80) ? OP_QUEUE : OP_TICK;
        send_beat(op, pick_ip(), 48'({$urandom(), $urandom()}));
      end
    end

    in_tvalid <= 1'b0;
    while (arp_answers.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d items (%0d ticks) and %0d result beats, %0d mismatches",
             n_items, n_ticks, n_beats, n_bad);
    if (n_bad == 0 && arp_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
src/arpc_pkg.sv
src/arpc_out_reg.sv
src/arp_cache_with_request_retry_top.sv
tb/sv/arp_cache_with_request_retry_top_test.sv
